@@ rtl/bitmap_slot_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Clocked, reset-gated property checks used by the allocator top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Field widths, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam int DEF_WORD_BITS  = 64;
  localparam int DEF_WORD_COUNT = 16;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

  // command codes; anything else is a no-op that reports ok
  localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_RANGE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TEST       = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SPLIT,
    S_READ,
    S_UPDATE,
    S_RANGE_RD,
    S_RANGE_WR,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                clear_step;
    logic                scan_step;
    logic                scan_take;
    logic                single_rd;
    logic                single_wr;
    logic                range_init;
    logic                range_step;
    logic                set_status;
    logic [STATUS_W-1:0] status_val;
    logic                load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             clear_last;
    logic             idx_bad;
    logic             range_bad;
    logic             len_zero;
    logic             found;
    logic             scan_over;
    logic             range_last;
    logic             rsp_busy;
  } dp_stat_t;

endpackage

@@ rtl/bitmap_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// One bit per slot, next-fit allocate, free, mark, mark range and test.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries cmd, entry_index and
//   range_length; a transaction completes when req_valid is high and
//   req_stall is low. Every request yields exactly one response transaction
//   on rsp_valid/rsp_stall with status, granted_slot and slot_used.
//   The slot_count register is written through cfg_valid/cfg_ready; the user
//   must write it only while the block is idle, which the block itself does not enforce; cfg_ready is always high.
// Sequence (from request to response valid):
//   free, mark, test: split, read, update; unknown command or slot out of
//   range: split only. mark range: split, first read, then one write per map
//   word touched; empty or bad range: split only. allocate: split, then a scan
//   from the hint word that wraps past the last word or a word above the slot
//   count, with one memory read per cycle, until a free slot or a full map.
//   The block takes one request at a time; the next request is taken the
//   cycle after the response is loaded, even while that response is stalled.
// Reset: rst (synchronous) clears the hint, the slot count (to 1024) and
//   starts a clearing pass that zeroes each word of the map memory; no
//   request is taken during it. A stalled response holds in the output
//   register and the next command waits in its final step until it drains.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_unit_assert.svh"

module bitmap_slot_allocator_unit #(
  parameter int WORD_BITS  = bsa_pkg::DEF_WORD_BITS,
  parameter int WORD_COUNT = bsa_pkg::DEF_WORD_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::COUNT_W-1:0]   slot_count,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [bsa_pkg::CMD_W-1:0]     cmd,
  input  logic [bsa_pkg::SLOT_W-1:0]    entry_index,
  input  logic [bsa_pkg::COUNT_W-1:0]   range_length,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  output logic                          slot_used
);

  bsa_pkg::ctrl_cmd_t ctl;
  bsa_pkg::dp_stat_t  dst;

  // config writes must be issued only while idle, which the block does not enforce; accept them at once
  assign cfg_ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .dst       (dst),
    .ctl       (ctl)
  );

  bsa_datapath #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_slot_count (slot_count),
    .req_cmd        (cmd),
    .req_index      (entry_index),
    .req_length     (range_length),
    .rsp_stall      (rsp_stall),
    .ctl            (ctl),
    .dst            (dst),
    .rsp_valid      (rsp_valid),
    .status         (status),
    .granted_slot   (granted_slot),
    .slot_used      (slot_used)
  );

  // one command in flight: stall the channel right after a transaction
  `BSA_ASSERT_NEXT(a_single_in_flight, req_valid && !req_stall, req_stall, "request taken while busy")

  // never overwrite a stalled response
  `BSA_ASSERT_NOW(a_no_overwrite, ctl.load_result, !(rsp_valid && rsp_stall), "response overwritten")

  // a full map hands out nothing
  `BSA_ASSERT_NOW(a_full_clean, rsp_valid && status == bsa_pkg::STAT_FULL, granted_slot == '0 && !slot_used, "full response carries data")

  // a grant and a map write happen together, only while scanning
  `BSA_ASSERT_NOW(a_take_on_found, ctl.scan_take, dst.found && !ctl.scan_step, "grant without free slot")

endmodule

@@ rtl/bsa_datapath.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Map memory, index split, allocate scan cursor, range cursor and the
// result register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
  parameter int WORD_BITS  = bsa_pkg::DEF_WORD_BITS,
  parameter int WORD_COUNT = bsa_pkg::DEF_WORD_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsa_pkg::COUNT_W-1:0]   cfg_slot_count,
  input  logic [bsa_pkg::CMD_W-1:0]     req_cmd,
  input  logic [bsa_pkg::SLOT_W-1:0]    req_index,
  input  logic [bsa_pkg::COUNT_W-1:0]   req_length,
  input  logic                          rsp_stall,
  input  bsa_pkg::ctrl_cmd_t            ctl,
  output bsa_pkg::dp_stat_t             dst,
  output logic                          rsp_valid,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  output logic                          slot_used
);

  localparam int SW     = bsa_pkg::SLOT_W;
  localparam int CW     = bsa_pkg::COUNT_W;
  localparam int WA     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BA     = $clog2(WORD_BITS);
  localparam int CAP    = WORD_BITS * WORD_COUNT;
  localparam int DIV_K  = 20;
  localparam int DIV_M  = (2 ** DIV_K) / WORD_BITS;
  localparam int PROD_W = SW + 18;

  localparam logic [WA-1:0] LAST_WORD = WA'(WORD_COUNT - 1);
  localparam logic [CW-1:0] W_CNT     = CW'(WORD_BITS);

  // configuration
  logic [CW-1:0] slot_count_cfg;
  logic [CW-1:0] limit;

  // request
  logic [bsa_pkg::CMD_W-1:0] cmd_code;
  logic [SW-1:0]             idx;
  logic [CW-1:0]             len;

  // index split
  logic [PROD_W-1:0] div_prod;
  logic [SW-1:0]     q_est;
  logic [SW-1:0]     base_est;
  logic [SW-1:0]     rem_est;
  logic [WA-1:0]     split_word;
  logic [BA-1:0]     split_bit;
  logic [SW-1:0]     split_base;

  // hint
  logic [WA-1:0] hint_word;
  logic [SW-1:0] hint_base;

  // scan cursor and evaluation stage
  logic [WA-1:0]        cur_word;
  logic [CW-1:0]        cur_base;
  logic                 cur_wrap;
  logic                 cur_done;
  logic                 cur_fruitless;
  logic                 cur_end;
  logic                 scan_issue;
  logic                 eval_valid;
  logic [WA-1:0]        eval_word;
  logic [CW-1:0]        eval_base;
  logic [CW-1:0]        eval_rem;
  logic [WORD_BITS-1:0] free_vec;
  logic [BA-1:0]        pick;
  logic [WORD_BITS-1:0] pick_onehot;

  // range cursor
  logic [WA-1:0]        rng_word;
  logic [BA-1:0]        rng_lo;
  logic [CW-1:0]        rng_rem;
  logic [CW-1:0]        rng_span;
  logic [CW-1:0]        rng_hi;
  logic                 rng_last;
  logic [WORD_BITS-1:0] rng_mask;

  // memory
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en;
  logic [WA-1:0]        rd_addr;
  logic                 wr_en;
  logic [WA-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WA-1:0]        clr_addr;
  logic [WORD_BITS-1:0] single_onehot;

  // working result
  logic [bsa_pkg::STATUS_W-1:0] res_status;
  logic [SW-1:0]                res_granted;
  logic                         res_used;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count_cfg <= bsa_pkg::SLOT_COUNT_RESET;
    end else if (cfg_we) begin
      slot_count_cfg <= cfg_slot_count;
    end
  end

  assign limit = (int'(slot_count_cfg) < CAP) ? slot_count_cfg : CW'(CAP);

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_code <= req_cmd;
      idx      <= req_index;
      len      <= req_length;
    end
  end

  // split slot into word and bit: reciprocal estimate, then one correction
  assign div_prod = PROD_W'(idx) * PROD_W'(DIV_M);
  assign base_est = SW'(32'(q_est) * WORD_BITS);
  assign rem_est  = idx - base_est;

  always_ff @(posedge clk) begin
    q_est <= SW'(div_prod >> DIV_K);
    if (rem_est >= SW'(WORD_BITS)) begin
      split_word <= WA'(q_est + 1'b1);
      split_bit  <= BA'(rem_est - SW'(WORD_BITS));
      split_base <= base_est + SW'(WORD_BITS);
    end else begin
      split_word <= WA'(q_est);
      split_bit  <= BA'(rem_est);
      split_base <= base_est;
    end
  end

  assign dst.cmd_code  = cmd_code;
  assign dst.idx_bad   = ({1'b0, idx} >= limit);
  assign dst.range_bad = dst.idx_bad || ((12'(idx) + 12'(len)) > 12'(limit));
  assign dst.len_zero  = (len == '0);

  // hint, moved by free
  always_ff @(posedge clk) begin
    if (rst) begin
      hint_word <= '0;
      hint_base <= '0;
    end else if (ctl.single_wr && cmd_code == bsa_pkg::CMD_FREE) begin
      hint_word <= split_word;
      hint_base <= split_base;
    end
  end

  // allocate scan: hint word up to the last word or the slot count, then word zero up to the hint word
  assign cur_fruitless = (cur_base >= limit);
  assign cur_end       = cur_wrap && (cur_word == hint_word);
  assign scan_issue    = ctl.scan_step && !cur_done && !cur_end && !cur_fruitless;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_done   <= 1'b0;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= scan_issue;
      if (ctl.accept) begin
        cur_done <= 1'b0;
      end else if (ctl.scan_step && !cur_done) begin
        if (cur_end || (cur_fruitless && cur_wrap)) begin
          cur_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_word <= hint_word;
      cur_base <= CW'(hint_base);
      cur_wrap <= 1'b0;
    end else if (ctl.scan_step && !cur_done && !cur_end) begin
      if (cur_fruitless || cur_word == LAST_WORD) begin
        cur_word <= '0;
        cur_base <= '0;
        cur_wrap <= 1'b1;
      end else begin
        cur_word <= WA'(cur_word + 1'b1);
        cur_base <= cur_base + W_CNT;
      end
    end
    if (scan_issue) begin
      eval_word <= cur_word;
      eval_base <= cur_base;
    end
  end

  assign eval_rem = limit - eval_base;

  always_comb begin
    free_vec = '0;
    pick     = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_vec[b] = !rd_data[b] && (CW'(b) < eval_rem);
    end
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        pick = BA'(b);
      end
    end
  end

  assign pick_onehot   = WORD_BITS'(1) << pick;
  assign dst.found     = eval_valid && (|free_vec);
  assign dst.scan_over = cur_done && !eval_valid;

  // range cursor: one word per cycle
  assign rng_span = W_CNT - CW'(rng_lo);
  assign rng_last = (rng_rem <= rng_span);
  assign rng_hi   = rng_last ? (CW'(rng_lo) + rng_rem) : W_CNT;

  always_comb begin
    rng_mask = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      rng_mask[b] = (CW'(b) >= CW'(rng_lo)) && (CW'(b) < rng_hi);
    end
  end

  assign dst.range_last = rng_last;

  always_ff @(posedge clk) begin
    if (ctl.range_init) begin
      rng_word <= split_word;
      rng_lo   <= split_bit;
      rng_rem  <= len;
    end else if (ctl.range_step && !rng_last) begin
      rng_word <= WA'(rng_word + 1'b1);
      rng_lo   <= '0;
      rng_rem  <= rng_rem - rng_span;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_step) begin
      clr_addr <= WA'(clr_addr + 1'b1);
    end
  end

  assign dst.clear_last = (clr_addr == LAST_WORD);

  // memory port selection
  assign single_onehot = WORD_BITS'(1) << split_bit;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_word;
    if (scan_issue) begin
      rd_en = 1'b1;
    end else if (ctl.single_rd || ctl.range_init) begin
      rd_en   = 1'b1;
      rd_addr = split_word;
    end else if (ctl.range_step && !rng_last) begin
      rd_en   = 1'b1;
      rd_addr = WA'(rng_word + 1'b1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (ctl.clear_step) begin
      wr_en = 1'b1;
    end else if (ctl.scan_take) begin
      wr_en   = 1'b1;
      wr_addr = eval_word;
      wr_data = rd_data | pick_onehot;
    end else if (ctl.single_wr && cmd_code == bsa_pkg::CMD_FREE) begin
      wr_en   = 1'b1;
      wr_addr = split_word;
      wr_data = rd_data & ~single_onehot;
    end else if (ctl.single_wr && cmd_code == bsa_pkg::CMD_MARK) begin
      wr_en   = 1'b1;
      wr_addr = split_word;
      wr_data = rd_data | single_onehot;
    end else if (ctl.range_step) begin
      wr_en   = 1'b1;
      wr_addr = rng_word;
      wr_data = rd_data | rng_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // working result
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res_status  <= bsa_pkg::STAT_OK;
      res_granted <= '0;
      res_used    <= 1'b0;
    end else begin
      if (ctl.set_status) begin
        res_status <= ctl.status_val;
      end
      if (ctl.scan_take) begin
        res_granted <= SW'(eval_base + CW'(pick));
      end
      if (ctl.single_wr && cmd_code == bsa_pkg::CMD_TEST) begin
        res_used <= rd_data[split_bit];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_result) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      status       <= res_status;
      granted_slot <= res_granted;
      slot_used    <= res_used;
    end
  end

  assign dst.rsp_busy = rsp_valid && rsp_stall;

endmodule

@@ rtl/bsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences the clearing pass and each command over the datapath.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  bsa_pkg::dp_stat_t  dst,
  output bsa_pkg::ctrl_cmd_t ctl
);

  bsa_pkg::state_t state;
  bsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsa_pkg::S_CLEAR: begin
        if (dst.clear_last) begin
          state_next = bsa_pkg::S_IDLE;
        end
      end
      bsa_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = bsa_pkg::S_DIV;
        end
      end
      bsa_pkg::S_DIV: begin
        state_next = bsa_pkg::S_SPLIT;
      end
      bsa_pkg::S_SPLIT: begin
        case (dst.cmd_code)
          bsa_pkg::CMD_ALLOC: begin
            state_next = bsa_pkg::S_SCAN;
          end
          bsa_pkg::CMD_FREE, bsa_pkg::CMD_MARK, bsa_pkg::CMD_TEST: begin
            state_next = dst.idx_bad ? bsa_pkg::S_DONE : bsa_pkg::S_READ;
          end
          bsa_pkg::CMD_MARK_RANGE: begin
            if (dst.range_bad || dst.len_zero) begin
              state_next = bsa_pkg::S_DONE;
            end else begin
              state_next = bsa_pkg::S_RANGE_RD;
            end
          end
          default: begin
            state_next = bsa_pkg::S_DONE;
          end
        endcase
      end
      bsa_pkg::S_READ: begin
        state_next = bsa_pkg::S_UPDATE;
      end
      bsa_pkg::S_UPDATE: begin
        state_next = bsa_pkg::S_DONE;
      end
      bsa_pkg::S_RANGE_RD: begin
        state_next = bsa_pkg::S_RANGE_WR;
      end
      bsa_pkg::S_RANGE_WR: begin
        if (dst.range_last) begin
          state_next = bsa_pkg::S_DONE;
        end
      end
      bsa_pkg::S_SCAN: begin
        if (dst.found || dst.scan_over) begin
          state_next = bsa_pkg::S_DONE;
        end
      end
      bsa_pkg::S_DONE: begin
        if (!dst.rsp_busy) begin
          state_next = bsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsa_pkg::S_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    req_stall = (state != bsa_pkg::S_IDLE);
    case (state)
      bsa_pkg::S_CLEAR: begin
        ctl.clear_step = 1'b1;
      end
      bsa_pkg::S_IDLE: begin
        ctl.accept = req_valid;
      end
      bsa_pkg::S_SPLIT: begin
        case (dst.cmd_code)
          bsa_pkg::CMD_FREE, bsa_pkg::CMD_MARK, bsa_pkg::CMD_TEST: begin
            ctl.set_status = dst.idx_bad;
            ctl.status_val = bsa_pkg::STAT_RANGE;
          end
          bsa_pkg::CMD_MARK_RANGE: begin
            ctl.set_status = dst.range_bad;
            ctl.status_val = bsa_pkg::STAT_RANGE;
          end
          default: begin
          end
        endcase
      end
      bsa_pkg::S_READ: begin
        ctl.single_rd = 1'b1;
      end
      bsa_pkg::S_UPDATE: begin
        ctl.single_wr = 1'b1;
      end
      bsa_pkg::S_RANGE_RD: begin
        ctl.range_init = 1'b1;
      end
      bsa_pkg::S_RANGE_WR: begin
        ctl.range_step = 1'b1;
      end
      bsa_pkg::S_SCAN: begin
        if (dst.found) begin
          ctl.scan_take = 1'b1;
        end else if (dst.scan_over) begin
          ctl.set_status = 1'b1;
          ctl.status_val = bsa_pkg::STAT_FULL;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      bsa_pkg::S_DONE: begin
        ctl.load_result = !dst.rsp_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/tb_bitmap_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Sends allocate, free, mark, mark-range, test and unknown commands through
// the request channel. A predictor keeps its own copy of the slot map, the
// free hint and the slot count, and each response is checked field by field
// against it. Both channels see random gaps and stalls, and the slot count is
// reprogrammed between phases, down to zero and up past the map capacity.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_unit;

  localparam int CMD_BITS    = bsa_pkg::CMD_W;
  localparam int SLOT_BITS   = bsa_pkg::SLOT_W;
  localparam int CNT_BITS    = bsa_pkg::COUNT_W;
  localparam int ST_BITS     = bsa_pkg::STATUS_W;
  localparam int MAP_BITS    = bsa_pkg::DEF_WORD_BITS;
  localparam int MAP_WORDS   = bsa_pkg::DEF_WORD_COUNT;
  localparam int MAP_SLOTS   = MAP_BITS * MAP_WORDS;
  localparam int CMD_MAX     = (1 << CMD_BITS) - 1;
  localparam int LEN_MAX     = (1 << CNT_BITS) - 1;
  localparam int SLOT_MAX    = (1 << SLOT_BITS) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 40;
  localparam int PRINT_CAP   = 100;

  // One response transaction as the block returns it
  typedef struct packed {
    logic [ST_BITS-1:0]   status;
    logic [SLOT_BITS-1:0] granted;
    logic                 used;
  } alloc_rsp_t;

  // DUT ports; every input starts at a known value
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CNT_BITS-1:0]  slot_count   = bsa_pkg::SLOT_COUNT_RESET;
  logic                 req_valid    = 1'b0;
  logic                 req_stall;
  logic [CMD_BITS-1:0]  cmd          = bsa_pkg::CMD_TEST;
  logic [SLOT_BITS-1:0] entry_index  = '0;
  logic [CNT_BITS-1:0]  range_length = '0;
  logic                 rsp_valid;
  logic                 rsp_stall    = 1'b0;
  logic [ST_BITS-1:0]   status;
  logic [SLOT_BITS-1:0] granted_slot;
  logic                 slot_used;

  // Predictor state: slot map, free hint and the programmed slot count
  logic [MAP_BITS-1:0]  slot_map [MAP_WORDS];
  logic [SLOT_BITS-1:0] free_hint;
  logic [CNT_BITS-1:0]  cfg_slot_count;

  alloc_rsp_t pending_results[$];
  alloc_rsp_t oldest_rsp;
  int         error_count = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  logic       quiet_mode  = 1'b0;

  bitmap_slot_allocator_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slot_count   (slot_count),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .range_length (range_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .slot_used    (slot_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP)
      $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Mostly back-to-back, sometimes a short gap, rarely a long pause; none in quiet mode
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode)
      return 0;
    if (roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    if (roll < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int active_limit();
    return (cfg_slot_count < MAP_SLOTS) ? int'(cfg_slot_count) : MAP_SLOTS;
  endfunction

  // Slot below the limit most of the time, any slot otherwise
  function automatic int pick_slot(input int lim);
    if (lim > 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, lim - 1);
    return $urandom_range(0, SLOT_MAX);
  endfunction

  // Predict the response of one command and advance the map, hint and state
  function automatic alloc_rsp_t predict_allocation(input logic [CMD_BITS-1:0] op,
                                                    input logic [SLOT_BITS-1:0] idx,
                                                    input logic [CNT_BITS-1:0] len);
    alloc_rsp_t rsp;
    int lim, start_word, w, b, s, k;
    bit got;
    rsp = '0;
    lim = active_limit();
    case (op)
      bsa_pkg::CMD_ALLOC: begin
        // next fit: hint word to the top, then wrap from word zero
        got = 1'b0;
        start_word = int'(free_hint) / MAP_BITS;
        if (start_word >= MAP_WORDS)
          start_word = 0;
        for (k = 0; k < MAP_WORDS && !got; k++) begin
          w = (start_word + k) % MAP_WORDS;
          for (b = 0; b < MAP_BITS && !got; b++) begin
            s = w * MAP_BITS + b;
            if (s < lim && !slot_map[w][b]) begin
              slot_map[w][b] = 1'b1;
              rsp.granted = s[SLOT_BITS-1:0];
              got = 1'b1;
            end
          end
        end
        if (!got)
          rsp.status = bsa_pkg::STAT_FULL;
      end
      bsa_pkg::CMD_FREE: begin
        if (idx >= lim) begin
          rsp.status = bsa_pkg::STAT_RANGE;
        end else begin
          slot_map[idx / MAP_BITS][idx % MAP_BITS] = 1'b0;
          free_hint = idx;
        end
      end
      bsa_pkg::CMD_MARK: begin
        if (idx >= lim)
          rsp.status = bsa_pkg::STAT_RANGE;
        else
          slot_map[idx / MAP_BITS][idx % MAP_BITS] = 1'b1;
      end
      bsa_pkg::CMD_MARK_RANGE: begin
        if (idx >= lim || int'(idx) + int'(len) > lim) begin
          rsp.status = bsa_pkg::STAT_RANGE;
        end else begin
          for (s = int'(idx); s < int'(idx) + int'(len); s++)
            slot_map[s / MAP_BITS][s % MAP_BITS] = 1'b1;
        end
      end
      bsa_pkg::CMD_TEST: begin
        if (idx >= lim)
          rsp.status = bsa_pkg::STAT_RANGE;
        else
          rsp.used = slot_map[idx / MAP_BITS][idx % MAP_BITS];
      end
      default: begin
        // unknown command: ok, nothing changes
      end
    endcase
    return rsp;
  endfunction

  // Send one request transaction after a random gap; predict it on acceptance
  task automatic send_request(input logic [CMD_BITS-1:0] op,
                              input logic [SLOT_BITS-1:0] idx,
                              input logic [CNT_BITS-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    cmd          <= op;
    entry_index  <= idx;
    range_length <= len;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_allocation(op, idx, len));
  endtask

  // Hold off the request side until every predicted response has arrived
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Program the slot count while the block sits idle
  task automatic write_slot_count(input logic [CNT_BITS-1:0] val);
    wait_drained();
    cfg_valid  <= 1'b1;
    slot_count <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_slot_count = val;
    cfg_valid <= 1'b0;
  endtask

  // Weighted mix: mostly legal commands on live slots, some out of range and
  // unknown codes, and ranges that usually fit
  task automatic send_random_request();
    int lim, pick, idx, len, room, op_code;
    logic [CMD_BITS-1:0] op;
    lim  = active_limit();
    pick = $urandom_range(0, 99);
    idx  = pick_slot(lim);
    len  = $urandom_range(0, LEN_MAX);
    if (pick < 30) begin
      op = bsa_pkg::CMD_ALLOC;
    end else if (pick < 52) begin
      op = bsa_pkg::CMD_FREE;
    end else if (pick < 62) begin
      op = bsa_pkg::CMD_MARK;
    end else if (pick < 77) begin
      op = bsa_pkg::CMD_TEST;
    end else if (pick < 92) begin
      op = bsa_pkg::CMD_MARK_RANGE;
      if (lim > idx && $urandom_range(0, 3) != 0) begin
        room = (lim - idx < 80) ? lim - idx : 80;
        len  = $urandom_range(0, room);
      end
    end else begin
      op_code = $urandom_range(int'(bsa_pkg::CMD_TEST) + 1, CMD_MAX);
      op      = op_code[CMD_BITS-1:0];
    end
    send_request(op, idx[SLOT_BITS-1:0], len[CNT_BITS-1:0]);
  endtask

  // Reprogram, optionally pre-fill a run of slots from zero, then run items
  task automatic run_random_phase(input logic [CNT_BITS-1:0] count, input int items,
                                  input int prefill, input logic quiet);
    write_slot_count(count);
    quiet_mode <= quiet;
    if (prefill > 0)
      send_request(bsa_pkg::CMD_MARK_RANGE, '0, prefill[CNT_BITS-1:0]);
    repeat (items) send_random_request();
  endtask

  // ---------------------------------------------------------------- tests

  // Fresh map after reset: everything free, first allocate gets slot zero
  task automatic test_reset_state();
    write_slot_count(bsa_pkg::SLOT_COUNT_RESET);
    send_request(bsa_pkg::CMD_TEST, '0, '0);
    send_request(bsa_pkg::CMD_ALLOC, SLOT_BITS'(SLOT_MAX), CNT_BITS'(LEN_MAX));
  endtask

  // Single-slot commands at the top slot, repeated mark and free, unknown codes
  task automatic test_single_slot_commands();
    send_request(bsa_pkg::CMD_MARK, SLOT_BITS'(SLOT_MAX), '0);
    send_request(bsa_pkg::CMD_TEST, SLOT_BITS'(SLOT_MAX), '0);
    send_request(bsa_pkg::CMD_FREE, SLOT_BITS'(SLOT_MAX), '0);
    // hint now in the top word: allocate starts its scan there
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_MARK, '0, '0);
    send_request(bsa_pkg::CMD_FREE, SLOT_BITS'(9), '0);
    send_request(bsa_pkg::CMD_FREE, SLOT_BITS'(9), '0);
    send_request(bsa_pkg::CMD_TEST + CMD_BITS'(1), SLOT_BITS'(SLOT_MAX), CNT_BITS'(LEN_MAX));
    send_request(CMD_BITS'(CMD_MAX), '0, '0);
  endtask

  // Range bounds, a full map, then allocate around the hint with wrap
  task automatic test_range_and_full();
    send_request(bsa_pkg::CMD_MARK_RANGE, '0, '0);
    send_request(bsa_pkg::CMD_MARK_RANGE, SLOT_BITS'(1), CNT_BITS'(MAP_SLOTS - 1));
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_MARK_RANGE, SLOT_BITS'(SLOT_MAX), CNT_BITS'(2));
    send_request(bsa_pkg::CMD_MARK_RANGE, '0, CNT_BITS'(LEN_MAX));
    send_request(bsa_pkg::CMD_FREE, SLOT_BITS'(640), '0);
    send_request(bsa_pkg::CMD_FREE, SLOT_BITS'(5), '0);
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
  endtask

  // Slot count above capacity, zero and one
  task automatic test_slot_count_limits();
    write_slot_count(CNT_BITS'(LEN_MAX));
    send_request(bsa_pkg::CMD_TEST, SLOT_BITS'(SLOT_MAX), '0);
    write_slot_count('0);
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_TEST, '0, '0);
    send_request(bsa_pkg::CMD_MARK_RANGE, '0, '0);
    write_slot_count(CNT_BITS'(1));
    send_request(bsa_pkg::CMD_FREE, '0, '0);
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_ALLOC, '0, '0);
    send_request(bsa_pkg::CMD_MARK, SLOT_BITS'(1), '0);
  endtask

  // Random phases over a spread of slot counts; small counts fill and wrap fast
  task automatic test_random_mix();
    run_random_phase(bsa_pkg::SLOT_COUNT_RESET, 300, 0, 1'b0);
    run_random_phase(CNT_BITS'(37), 200, 0, 1'b0);
    run_random_phase(CNT_BITS'(LEN_MAX), 220, 1000, 1'b0);
    run_random_phase(CNT_BITS'(130), 200, 0, 1'b0);
    run_random_phase(CNT_BITS'(1), 80, 0, 1'b0);
    run_random_phase('0, 40, 0, 1'b0);
    // no idling on either side for this stretch
    run_random_phase(CNT_BITS'(700), 260, 0, 1'b1);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int w = 0; w < MAP_WORDS; w++)
      slot_map[w] = '0;
    free_hint      = '0;
    cfg_slot_count = bsa_pkg::SLOT_COUNT_RESET;
    // hold reset at start; the clearing pass shows up as request stall
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_single_slot_commands();
    test_range_and_full();
    test_slot_count_limits();
    test_random_mix();
    // drop valid, let every response drain, then watch for strays
    wait_drained();
    quiet_mode <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Response side: random stall runs, none while quiet_mode is set
  always @(posedge clk) begin
    if (stall_left == 0 && !quiet_mode && $urandom_range(0, 3) == 0)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected: status %0d slot %0d used %0b",
                                  status, granted_slot, slot_used));
      end else begin
        oldest_rsp = pending_results.pop_front();
        if (status !== oldest_rsp.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, oldest_rsp.status));
        if (granted_slot !== oldest_rsp.granted)
          report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                    granted_slot, oldest_rsp.granted));
        if (slot_used !== oldest_rsp.used)
          report_mismatch($sformatf("slot_used %0b, expected %0b", slot_used, oldest_rsp.used));
      end
    end
  end

  // Watchdog: abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
